@@ rtl/sarr_pkg.sv @@
// package: types, constants and hash helpers for the rrip replacement core
package sarr_pkg;

  localparam int NUM_SETS      = 2048;
  localparam int NUM_WAYS      = 16;
  localparam int REUSE_ENTRIES = 2048;
  localparam int LEADER_COUNT  = 32;

  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int SIG_W  = $clog2(REUSE_ENTRIES);
  localparam int ROW_RV_W = 2 * NUM_WAYS;
  localparam int ROW_H_W  = 6 * NUM_WAYS;
  // per-set row: last address, stride count, streaming flag
  localparam int SROW_W = 64 + 8 + 1;
  localparam int CLR_W  = (SET_W > SIG_W) ? SET_W : SIG_W;
  localparam int CLR_MAX = (NUM_SETS > REUSE_ENTRIES) ? NUM_SETS : REUSE_ENTRIES;

  localparam logic [9:0] SEL_RESET = 10'd512;
  localparam logic [9:0] SEL_MAX   = 10'd1023;
  localparam logic [6:0] THR_RESET = 7'd8;
  localparam logic [3:0] AMM_RESET = 4'd2;

  localparam logic CFG_STREAM_THRESHOLD = 1'b0;
  localparam logic CFG_ADDR_MATCH_MIN   = 1'b1;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic        op;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [63:0] pc;
    logic [63:0] paddr;
    logic        hit;
    logic [15:0] valid_mask;
    logic [4:0]  random_bits;
  } in_item_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] insert_value;
    logic       set_streaming;
    logic [9:0] selector_value;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic exec;
    logic out_valid;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
  } dp_sts_t;

  function automatic logic [SIG_W-1:0] pc_sig(input logic [63:0] pc);
    logic [63:0] x;
    x = (pc >> 2) ^ (pc >> 5) ^ (pc >> 12);
    return x[SIG_W-1:0];
  endfunction

  function automatic logic [5:0] line_hash(input logic [63:0] a);
    logic [63:0] x;
    x = (a >> 6) ^ (a >> 13) ^ (a >> 21);
    return x[5:0];
  endfunction

  function automatic logic leader_a(input logic [SET_W-1:0] s);
    logic r;
    r = 1'b0;
    for (int i = 0; i < LEADER_COUNT; i++) begin
      if (SET_W'((i * 13) % NUM_SETS) == s) r = 1'b1;
    end
    return r;
  endfunction

  function automatic logic leader_b(input logic [SET_W-1:0] s);
    logic r;
    r = 1'b0;
    for (int i = 0; i < LEADER_COUNT; i++) begin
      if (SET_W'((i * 31 + 37) % NUM_SETS) == s) r = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/sarr_ram.sv @@
// generic single-port-write ram with registered read
module sarr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/sarr_ctrl.sv @@
// controller: clearing pass, read, execute and output sequencing
module sarr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  output sarr_pkg::dp_cmd_t cmd,
  input  sarr_pkg::dp_sts_t sts
);
  import sarr_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

`ifndef SYNTHESIS
  a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> state_r == ST_EXEC) else $error("read not followed by exec");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall) else $error("accept while busy");
  a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> cmd.out_valid) else $error("exec without output");
`endif
endmodule

@@ rtl/sarr_dp.sv @@
// datapath: set rows, reuse table, stride tracking, selector and result register
module sarr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sarr_pkg::dp_cmd_t   cmd,
  output sarr_pkg::dp_sts_t   sts,
  input  sarr_pkg::in_item_t  in_data,
  output sarr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data
);
  import sarr_pkg::*;

  in_item_t        item_r;
  logic [6:0]      thr_r;
  logic [3:0]      amm_r;
  logic [9:0]      sel_r, sel_nxt;
  logic [CLR_W:0]  clr_r;
  out_item_t       res_r, res_nxt;

  logic [SET_W-1:0] set_w;
  logic [WAY_W-1:0] way_w;
  logic [SIG_W-1:0] sig_w;
  assign set_w = item_r.set_index[SET_W-1:0];
  assign way_w = item_r.way_index[WAY_W-1:0];
  assign sig_w = pc_sig(item_r.pc);

  logic [ROW_RV_W-1:0] rv_rd, rv_wd;
  logic [ROW_H_W-1:0]  h_rd, h_wd;
  logic [SROW_W-1:0]   s_rd, s_wd;
  logic [1:0]          ru_rd, ru_wd;
  logic                wr_en;

  logic clearing;
  assign clearing = cmd.clear_en && (clr_r < (CLR_W+1)'(CLR_MAX));
  assign sts.clear_done = !clearing;

  logic [SET_W-1:0] set_wa;
  logic [SIG_W-1:0] sig_wa;
  assign set_wa = cmd.clear_en ? clr_r[SET_W-1:0] : set_w;
  assign sig_wa = cmd.clear_en ? clr_r[SIG_W-1:0] : sig_w;

  logic set_clr_we, sig_clr_we;
  assign set_clr_we = clearing && (clr_r < (CLR_W+1)'(NUM_SETS));
  assign sig_clr_we = clearing && (clr_r < (CLR_W+1)'(REUSE_ENTRIES));

  sarr_ram #(.WIDTH(ROW_RV_W), .DEPTH(NUM_SETS)) u_rv (
    .clk, .we(set_clr_we || wr_en), .waddr(set_wa),
    .wdata(cmd.clear_en ? {ROW_RV_W{1'b1}} : rv_wd),
    .raddr(set_w), .rdata(rv_rd));
  sarr_ram #(.WIDTH(ROW_H_W), .DEPTH(NUM_SETS)) u_hash (
    .clk, .we(set_clr_we || (wr_en && item_r.op == OP_UPDATE)), .waddr(set_wa),
    .wdata(cmd.clear_en ? '0 : h_wd),
    .raddr(set_w), .rdata(h_rd));
  sarr_ram #(.WIDTH(SROW_W), .DEPTH(NUM_SETS)) u_set (
    .clk, .we(set_clr_we || (wr_en && item_r.op == OP_UPDATE)), .waddr(set_wa),
    .wdata(cmd.clear_en ? '0 : s_wd),
    .raddr(set_w), .rdata(s_rd));
  sarr_ram #(.WIDTH(2), .DEPTH(REUSE_ENTRIES)) u_reuse (
    .clk, .we(sig_clr_we || (wr_en && item_r.op == OP_UPDATE)), .waddr(sig_wa),
    .wdata(cmd.clear_en ? '0 : ru_wd),
    .raddr(sig_w), .rdata(ru_rd));

  assign wr_en = cmd.exec;

  always_comb begin
    logic [1:0]  mx;
    logic [1:0]  add;
    logic        found, strm_lo, la, lb, strm;
    logic [63:0] last, d;
    logic signed [7:0] c;
    logic [5:0]  h;
    logic [4:0]  match;
    logic [1:0]  ins, ru_new;
    logic [7:0]  thr8;
    rv_wd = rv_rd;
    h_wd = h_rd;
    s_wd = s_rd;
    ru_wd = ru_rd;
    sel_nxt = sel_r;
    res_nxt = '0;
    mx = 2'd0;
    add = 2'd0;
    found = 1'b0;
    strm_lo = 1'b0;
    ins = 2'd0;
    match = '0;
    last = s_rd[SROW_W-1 -: 64];
    c = s_rd[8:1];
    strm = s_rd[0];
    d = item_r.paddr - last;
    h = line_hash(item_r.paddr);
    la = leader_a(set_w);
    lb = leader_b(set_w);
    ru_new = ru_rd;
    thr8 = {1'b0, thr_r};
    if (item_r.op == OP_VICTIM) begin
      strm_lo = strm && (ru_rd < 2'd2);
      if (strm_lo) begin
        for (int k = NUM_WAYS - 1; k >= 0; k--) begin
          if (k < 16 && !item_r.valid_mask[k]) begin
            res_nxt.victim_way = 4'(k);
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        for (int k = 0; k < NUM_WAYS; k++)
          if (rv_rd[2*k +: 2] > mx) mx = rv_rd[2*k +: 2];
        if (!strm_lo && mx < 2'd3) begin
          add = 2'd3 - mx;
          for (int k = 0; k < NUM_WAYS; k++) rv_wd[2*k +: 2] = rv_rd[2*k +: 2] + add;
          mx = 2'd3;
        end
        for (int k = NUM_WAYS - 1; k >= 0; k--)
          if (rv_wd[2*k +: 2] == mx) res_nxt.victim_way = 4'(k);
      end
      res_nxt.set_streaming = strm;
    end else begin
      if (last != 64'd0) begin
        if (d == 64'd64) begin
          if (c < 8'sd127) c = c + 8'sd1;
        end else if (d == 64'hFFFF_FFFF_FFFF_FFC0) begin
          if (c > -8'sd127) c = c - 8'sd1;
        end else if (d != 64'd0) begin
          c = '0;
        end
        if ($signed({1'b0, thr8}) <= $signed({c[7], c}) ||
            $signed({c[7], c}) <= -$signed({1'b0, thr8})) strm = 1'b1;
        else if (c == 8'sd0) strm = 1'b0;
      end
      s_wd = {item_r.paddr, c, strm};
      if (item_r.hit) begin
        if (ru_rd < 2'd3) ru_new = ru_rd + 2'd1;
      end else if (ru_rd > 2'd0) ru_new = ru_rd - 2'd1;
      ru_wd = ru_new;
      h_wd[6*way_w +: 6] = h;
      if (la) ins = 2'd2;
      else if (lb) ins = (item_r.random_bits == 5'd0) ? 2'd2 : 2'd3;
      else ins = (sel_r > SEL_RESET) ? 2'd2 : ((item_r.random_bits == 5'd0) ? 2'd2 : 2'd3);
      if (ru_new >= 2'd2) ins = 2'd0;
      for (int k = 0; k < NUM_WAYS; k++)
        if (WAY_W'(k) != way_w && h_rd[6*k +: 6] == h) match = match + 5'd1;
      if (match >= {1'b0, amm_r}) ins = 2'd0;
      if (strm && ru_new < 2'd2) ins = 2'd3;
      rv_wd[2*way_w +: 2] = ins;
      if (la) begin
        if (item_r.hit) begin
          if (sel_nxt < SEL_MAX) sel_nxt = sel_nxt + 10'd1;
        end else if (sel_nxt > 10'd0) sel_nxt = sel_nxt - 10'd1;
      end
      if (lb) begin
        if (item_r.hit) begin
          if (sel_nxt > 10'd0) sel_nxt = sel_nxt - 10'd1;
        end else if (sel_nxt < SEL_MAX) sel_nxt = sel_nxt + 10'd1;
      end
      res_nxt.insert_value = ins;
      res_nxt.set_streaming = strm;
    end
    res_nxt.selector_value = sel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= SEL_RESET;
      thr_r <= THR_RESET;
      amm_r <= AMM_RESET;
      clr_r <= '0;
    end else begin
      if (clearing) clr_r <= clr_r + 1'b1;
      if (cmd.exec) sel_r <= sel_nxt;
      if (cfg_valid && cfg_index == CFG_STREAM_THRESHOLD) thr_r <= cfg_data;
      if (cfg_valid && cfg_index == CFG_ADDR_MATCH_MIN) amm_r <= cfg_data[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.exec) res_r <= res_nxt;
  end

  assign out_data = res_r;

`ifndef SYNTHESIS
  a_sel_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cmd.exec) |-> $stable(sel_r)) else $error("selector moved outside exec");
  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !cmd.exec && !cmd.load) else $error("item during clear");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_valid && $past(cmd.out_valid) |-> $stable(res_r)) else $error("result changed");
`endif
endmodule

@@ rtl/streaming_aware_rrip_replacement_core.sv @@
// top level: llc replacement engine with srrip, reuse counters, stride detector and dueling
// use: one item per access on in_*, op 0 asks for a victim way, op 1 updates after hit/fill.
// each item gives one result on out_*: victim way, insert value, streaming flag, selector.
// an item is taken when in_valid is high and in_stall low; out_valid holds the result
// until out_stall is low at a clock edge.
// sequence: accept, a read state for the registered row reads, a state of compute and
// write back, then the result is shown.
// the rate is set by the per-set row ram: one read and one write back per item.
// cfg_valid/cfg_ready write stream_threshold (index 0) or addr_match_min (index 1);
// cfg_ready is always high; write only when no item is in flight.
// after reset a clearing pass sweeps all 2048 entries of the set and reuse rams
// while in_stall stays high; configuration writes are taken during it.
// a stalled result holds, and no new item is taken until it has been delivered.
module streaming_aware_rrip_replacement_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sarr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sarr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data
);
  import sarr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;
  assign out_valid = cmd.out_valid;

  sarr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_stall, .cmd, .sts);

  sarr_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_data, .out_data,
    .cfg_valid, .cfg_index, .cfg_data);
endmodule
